FILE: design/yuv2rgb_pkg.sv
// Shared types and fixed-point constants for the 4:2:0 block to RGB converter.
// No dependencies; used by yuv2rgb_lane and yuv420_block_to_rgb.
package yuv2rgb_pkg;

    // A chroma term, signed, wide enough for every channel.
    typedef logic signed [15:0] chroma_t;

    // A scaled luma term, (149 * Y) >> 1 with Y floored at 16.
    typedef logic [14:0] luma_t;

    // Per-stage load enables handed from the pipeline control to each lane.
    typedef struct packed {
        logic s2_en;
        logic s3_en;
    } stage_ctl_t;

    // Luma scale and floor.
    localparam logic [7:0] LumaFloor = 8'd16;
    localparam logic [7:0] LumaScale = 8'd149;

    // Chroma coefficients and offsets (BT.601 studio range).
    localparam chroma_t    RedBias   = -16'sd14248;
    localparam logic [6:0] RedCoefV  = 7'd102;
    localparam chroma_t    GrnBias   = 16'sd8663;
    localparam logic [4:0] GrnCoefU  = 5'd25;
    localparam logic [5:0] GrnCoefV  = 6'd52;
    localparam chroma_t    BluBias   = -16'sd17705;
    localparam logic [7:0] BluCoefU  = 8'd129;

    // Rounding term added after the halving shift.
    localparam logic signed [16:0] RoundBias = 17'sd16;

endpackage

FILE: design/yuv2rgb_lane.sv
// One pixel lane: scaled luma plus the three chroma terms, then halve, round, shift, clamp.
// Depends on yuv2rgb_pkg for the term types and the stage enable struct.
module yuv2rgb_lane (
    input  logic                   clk,
    input  yuv2rgb_pkg::stage_ctl_t ctl,
    input  yuv2rgb_pkg::luma_t     luma_term,
    input  yuv2rgb_pkg::chroma_t   term_r,
    input  yuv2rgb_pkg::chroma_t   term_g,
    input  yuv2rgb_pkg::chroma_t   term_b,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue
);

    logic signed [16:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic signed [16:0] sum_r_next, sum_g_next, sum_b_next;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic [7:0]         red_next, green_next, blue_next;
    logic signed [16:0] luma_ext;

    // Stage 2: add the luma term to each chroma term.
    assign luma_ext   = $signed({2'b00, luma_term});
    assign sum_r_next = luma_ext + {term_r[15], term_r};
    assign sum_g_next = luma_ext + {term_g[15], term_g};
    assign sum_b_next = luma_ext + {term_b[15], term_b};

    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Halve with a floor shift, add the rounding bias, drop five bits and clamp to a byte.
    function automatic logic [7:0] to_byte(input logic signed [16:0] sum);
        logic signed [16:0] half;
        logic signed [16:0] rounded;
        logic signed [16:0] scaled;
        half    = sum >>> 1;
        rounded = half + yuv2rgb_pkg::RoundBias;
        scaled  = rounded >>> 5;
        if (scaled[16])
            to_byte = 8'd0;
        else if (|scaled[15:8])
            to_byte = 8'hFF;
        else
            to_byte = scaled[7:0];
    endfunction

    // Stage 3: output bytes.
    assign red_next   = to_byte(sum_r_reg);
    assign green_next = to_byte(sum_g_reg);
    assign blue_next  = to_byte(sum_b_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: design/yuv420_block_to_rgb.sv
// Top level: BT.601 fixed-point conversion of one 4:2:0 2x2 block to twelve RGB bytes.
// Depends on yuv2rgb_pkg and instantiates four yuv2rgb_lane pixel lanes.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   blk     | blk_valid, blk_stall | four luma bytes, chroma_u, chroma_v
//   pix     | pix_valid, pix_stall | red/green/blue of the four pixels
//
// One block is accepted per cycle while blk_stall is low; each beat passes the stage 1, 2 and 3 registers in turn.
// The three stages are: luma scale and chroma products, channel sums, round and clamp.
// Reset clears only the stage valid bits; nothing else is kept between blocks.
// A stall on the pix side only backs up the stages that hold data, so bubbles are
// squeezed out and blk_stall rises only when all three stages are full.
module yuv420_block_to_rgb (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       blk_valid,
    output logic       blk_stall,
    input  logic [7:0] luma_top_left,
    input  logic [7:0] luma_top_right,
    input  logic [7:0] luma_bottom_left,
    input  logic [7:0] luma_bottom_right,
    input  logic [7:0] chroma_u,
    input  logic [7:0] chroma_v,
    output logic       pix_valid,
    input  logic       pix_stall,
    output logic [7:0] red_top_left,
    output logic [7:0] green_top_left,
    output logic [7:0] blue_top_left,
    output logic [7:0] red_top_right,
    output logic [7:0] green_top_right,
    output logic [7:0] blue_top_right,
    output logic [7:0] red_bottom_left,
    output logic [7:0] green_bottom_left,
    output logic [7:0] blue_bottom_left,
    output logic [7:0] red_bottom_right,
    output logic [7:0] green_bottom_right,
    output logic [7:0] blue_bottom_right
);

    localparam int NumPix = 4;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 rdy1, rdy2, rdy3;
    logic                 s1_en;
    yuv2rgb_pkg::stage_ctl_t ctl;

    logic [7:0]           luma_in [NumPix];
    yuv2rgb_pkg::luma_t   luma_reg  [NumPix];
    yuv2rgb_pkg::luma_t   luma_next [NumPix];
    logic [7:0]           red_out   [NumPix];
    logic [7:0]           green_out [NumPix];
    logic [7:0]           blue_out  [NumPix];

    logic [14:0]          prod_rv;
    logic [12:0]          prod_gu;
    logic [13:0]          prod_gv;
    logic [15:0]          prod_bu;
    yuv2rgb_pkg::chroma_t term_r_reg, term_g_reg, term_b_reg;
    yuv2rgb_pkg::chroma_t term_r_next, term_g_next, term_b_next;

    // Pipeline control: a stage loads when it is empty or the stage after it moves.
    assign rdy3      = !v3_reg || !pix_stall;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign blk_stall = !rdy1;
    assign s1_en     = rdy1 && blk_valid;
    assign ctl       = '{s2_en: rdy2 && v1_reg, s3_en: rdy3 && v2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= blk_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    assign pix_valid = v3_reg;

    // Stage 1: chroma products shared by the block.
    assign prod_rv     = 15'(yuv2rgb_pkg::RedCoefV) * 15'(chroma_v);
    assign prod_gu     = 13'(yuv2rgb_pkg::GrnCoefU) * 13'(chroma_u);
    assign prod_gv     = 14'(yuv2rgb_pkg::GrnCoefV) * 14'(chroma_v);
    assign prod_bu     = 16'(yuv2rgb_pkg::BluCoefU) * 16'(chroma_u);
    assign term_r_next = yuv2rgb_pkg::RedBias + $signed({1'b0, prod_rv});
    assign term_g_next = yuv2rgb_pkg::GrnBias - $signed({3'b000, prod_gu})
                         - $signed({2'b00, prod_gv});
    // The blue sum always fits in 16 signed bits, so wrapping addition is exact.
    assign term_b_next = yuv2rgb_pkg::BluBias + $signed(prod_bu);

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            term_r_reg <= term_r_next;
            term_g_reg <= term_g_next;
            term_b_reg <= term_b_next;
        end
    end

    // Stage 1: floor each luma at 16 and scale it.
    assign luma_in[0] = luma_top_left;
    assign luma_in[1] = luma_top_right;
    assign luma_in[2] = luma_bottom_left;
    assign luma_in[3] = luma_bottom_right;

    always_comb
    begin
        logic [7:0]  floored;
        logic [15:0] prod;
        for (int i = 0; i < NumPix; i++)
        begin
            floored      = (luma_in[i] < yuv2rgb_pkg::LumaFloor) ?
                           yuv2rgb_pkg::LumaFloor : luma_in[i];
            prod         = 16'(yuv2rgb_pkg::LumaScale) * 16'(floored);
            luma_next[i] = prod[15:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            luma_reg <= luma_next;
    end

    // Stages 2 and 3: one lane per pixel.
    for (genvar g = 0; g < NumPix; g++)
    begin : g_lane
        yuv2rgb_lane u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .luma_term (luma_reg[g]),
            .term_r    (term_r_reg),
            .term_g    (term_g_reg),
            .term_b    (term_b_reg),
            .red       (red_out[g]),
            .green     (green_out[g]),
            .blue      (blue_out[g])
        );
    end

    assign red_top_left       = red_out[0];
    assign green_top_left     = green_out[0];
    assign blue_top_left      = blue_out[0];
    assign red_top_right      = red_out[1];
    assign green_top_right    = green_out[1];
    assign blue_top_right     = blue_out[1];
    assign red_bottom_left    = red_out[2];
    assign green_bottom_left  = green_out[2];
    assign blue_bottom_left   = blue_out[2];
    assign red_bottom_right   = red_out[3];
    assign green_bottom_right = green_out[3];
    assign blue_bottom_right  = blue_out[3];

    // The input side may only back up when every stage holds a beat.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> (v1_reg && v2_reg && v3_reg && pix_stall))
        else $error("blk_stall raised with a free stage");

    // An accepted beat lands in stage 1.
    a_accept_v1: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_valid && !blk_stall) |=> v1_reg)
        else $error("accepted beat missing from stage 1");

    // A beat in stage 2 reaches the output when the output is not stalled.
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !pix_stall) |=> pix_valid)
        else $error("stage 2 beat lost on its way out");

    // A stalled output with a full stage 2 keeps stage 2 full.
    a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_stall && v2_reg) |=> v2_reg)
        else $error("stage 2 beat dropped under stall");

endmodule
